// ===== hw/rtl/mdet_pkg.sv =====
// ============================================================================
// mdet_pkg: shared types and tables for the 4x4 determinant unit
// Holds the default sizes, the digit width of the serial multiplier, the
// sequencer phase type, the multiplier control struct and the column-pair
// tables used for the expansion by complementary 2x2 minors.
// ============================================================================
package mdet_pkg;

	// Widths fixed by the request format.
	localparam int FIELD_W = 16;
	localparam int OUT_W = 64;
	localparam int OUT_FRAC = 32;

	// Default configuration.
	localparam int ENTRY_WIDTH_DEF = 16;
	localparam int FRACTION_BITS_DEF = 8;

	// Multiplier digit width: bits of the serial operand consumed per cycle.
	localparam int DIGIT_BITS = 4;

	// Six column pairs of a 4-column matrix.
	localparam int NPAIR = 6;

	typedef logic [2:0] pair_idx_t;
	typedef logic [1:0] col_idx_t;

	// Sequencer phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_MTOP,
		PH_MBOT,
		PH_EXPAND,
		PH_SCALE
	} phase_t;

	// Command to the digit-serial multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic neg;
		logic clear;
		logic long_op;
	} mac_ctrl_t;

	// Lower column of a column pair.
	function automatic col_idx_t pair_lo(input pair_idx_t p);
		col_idx_t c;
		unique case (p)
			3'd0, 3'd1, 3'd2: c = 2'd0;
			3'd3, 3'd4: c = 2'd1;
			3'd5: c = 2'd2;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	// Upper column of a column pair.
	function automatic col_idx_t pair_hi(input pair_idx_t p);
		col_idx_t c;
		unique case (p)
			3'd0: c = 2'd1;
			3'd1, 3'd3: c = 2'd2;
			3'd2, 3'd4, 3'd5: c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	// Sign of the Laplace term for a pair of rows zero and one; the
	// complementary pair is found at index NPAIR-1-p.
	function automatic logic pair_neg(input pair_idx_t p);
		logic n;
		unique case (p)
			3'd1, 3'd4: n = 1'b1;
			default: n = 1'b0;
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/mdet_serial_mac.sv =====
// ============================================================================
// mdet_serial_mac: digit-serial multiply-accumulate unit
// Multiplies a parallel operand by a serial operand that is shifted out
// most significant digit first, then adds or subtracts the product into
// a wide accumulator. One digit per cycle, then an accumulate step at the end.
// ============================================================================
module mdet_serial_mac
	import mdet_pkg::*;
#(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  mac_ctrl_t ctrl,
	input  logic signed [2*ENTRY_WIDTH:0] x_in,
	input  logic signed [DIGIT_BITS*((2*ENTRY_WIDTH+DIGIT_BITS)/DIGIT_BITS)-1:0] y_in,
	output logic done,
	output logic signed [4*ENTRY_WIDTH+1:0] sum,
	output logic signed [4*ENTRY_WIDTH+1:0] acc
);

	localparam int XW = 2*ENTRY_WIDTH + 1;
	localparam int ND_E = (ENTRY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int ND_M = (XW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int YW = ND_M * DIGIT_BITS;
	localparam int ACC_W = 4*ENTRY_WIDTH + 2;
	localparam int CNT_W = $clog2(ND_M + 1);

	logic run_q;
	logic add_q;
	logic first_q;
	logic neg_q;
	logic clr_q;
	logic [CNT_W-1:0] dig_q;
	logic signed [XW-1:0] x_q;
	logic [YW-1:0] y_q;
	logic signed [ACC_W-1:0] prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic [DIGIT_BITS-1:0] digit;
	logic signed [DIGIT_BITS:0] dsx;
	logic signed [XW+DIGIT_BITS:0] pp;
	logic signed [ACC_W-1:0] prod_nxt;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;

	// The top digit carries the sign; all later digits are unsigned.
	always_comb begin
		digit = y_q[YW-1 -: DIGIT_BITS];
		dsx = first_q ? {digit[DIGIT_BITS-1], digit} : {1'b0, digit};
		pp = x_q * dsx;
		prod_nxt = (prod_q <<< DIGIT_BITS) + ACC_W'(pp);
	end

	// Accumulate step: optional clear, then add or subtract the product.
	always_comb begin
		term = neg_q ? -prod_q : prod_q;
		base = clr_q ? '0 : acc_q;
		sum = base + term;
	end

	assign done = add_q;
	assign acc = acc_q;

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			add_q <= 1'b0;
		end else begin
			add_q <= 1'b0;
			if (ctrl.start) begin
				run_q <= 1'b1;
			end else if (run_q && dig_q == CNT_W'(1)) begin
				run_q <= 1'b0;
				add_q <= 1'b1;
			end
		end
	end

	// Operand shift register, partial product and accumulator.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= x_in;
			y_q <= y_in;
			dig_q <= ctrl.long_op ? CNT_W'(ND_M) : CNT_W'(ND_E);
			first_q <= 1'b1;
			prod_q <= '0;
			neg_q <= ctrl.neg;
			clr_q <= ctrl.clear;
		end else if (run_q) begin
			prod_q <= prod_nxt;
			y_q <= y_q << DIGIT_BITS;
			first_q <= 1'b0;
			dig_q <= dig_q - CNT_W'(1);
		end
		if (add_q) begin
			acc_q <= sum;
		end
	end

endmodule

// ===== hw/rtl/matrix4_determinant_unit.sv =====
// ============================================================================
// matrix4_determinant_unit: 4x4 fixed-point determinant, one row per request
// Collects four rows, forms the 2x2 minors of rows zero/one and two/three,
// and expands by complementary minors into a Q32.32 saturated result.
// ============================================================================
//
//   channel   | signals                                     | direction
//   ----------+---------------------------------------------+----------
//   input     | in_valid, in_stall, entry_a .. entry_d      | row in
//   output    | out_valid, out_stall, determinant, saturated | result out
//
// All products go through one digit-serial multiply-accumulate unit that
// consumes four operand bits a cycle. A product of row entries has NE
// digits (NE = ceil(ENTRY_WIDTH/4), 4 at 16 bits) and a product of two
// minors NM digits (NM = ceil((2*ENTRY_WIDTH+1)/4), 9 at 16 bits).
// After row one, twelve products build the top minors; row two is taken
// meanwhile, row three waits. Row zero of the next matrix is taken while the
// rest runs, its row one waits for the unit.
// After row three the unit builds the bottom minors, expands and rescales;
// a finished result waits while the previous one is held.
// Reset clears the row count, the sequencer and the output valid flag.
// ============================================================================
module matrix4_determinant_unit
	import mdet_pkg::*;
#(
	parameter int ENTRY_WIDTH = ENTRY_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [FIELD_W-1:0] entry_a,
	input  logic signed [FIELD_W-1:0] entry_b,
	input  logic signed [FIELD_W-1:0] entry_c,
	input  logic signed [FIELD_W-1:0] entry_d,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [OUT_W-1:0] determinant,
	output logic saturated
);

	localparam int XW = 2*ENTRY_WIDTH + 1;
	localparam int ND_E = (ENTRY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int ND_M = (XW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int YE_W = ND_E * DIGIT_BITS;
	localparam int YW = ND_M * DIGIT_BITS;
	localparam int YSH = YW - YE_W;
	localparam int ACC_W = 4*ENTRY_WIDTH + 2;
	localparam int WIDE_W = ACC_W + OUT_FRAC;
	localparam int SHL = (4*FRACTION_BITS < OUT_FRAC) ? OUT_FRAC - 4*FRACTION_BITS : 0;
	localparam int SHR = (4*FRACTION_BITS > OUT_FRAC) ? 4*FRACTION_BITS - OUT_FRAC : 0;
	localparam logic [3:0] LAST_MIN = 4'(2*NPAIR - 1);
	localparam logic [3:0] LAST_EXP = 4'(NPAIR - 1);

	typedef logic [3:0][ENTRY_WIDTH-1:0] row_t;

	phase_t phase_q, phase_d;
	logic [3:0] op_q, op_d;
	logic inflight_q, inflight_d;
	logic [1:0] cnt_q, cnt_d;
	logic out_valid_q, out_valid_d;
	logic load_out;
	logic busy;
	logic accept;

	row_t row0_q, row1_q, row2_q, row3_q;
	row_t new_row;
	logic signed [XW-1:0] m01_q [NPAIR];
	logic signed [XW-1:0] m23_q [NPAIR];
	logic signed [OUT_W-1:0] det_q;
	logic sat_q;

	mac_ctrl_t mac_ctrl;
	logic signed [XW-1:0] mac_x;
	logic signed [YW-1:0] mac_y;
	logic signed [YW-1:0] y_ent;
	logic mac_done;
	logic signed [ACC_W-1:0] mac_sum;
	logic signed [ACC_W-1:0] mac_acc;

	pair_idx_t pidx;
	col_idx_t xcol, ycol;
	row_t upper, lower;
	logic [ENTRY_WIDTH-1:0] xe, ye;

	logic signed [WIDE_W-1:0] wide_ext, scaled;
	logic [WIDE_W-OUT_W:0] hi_bits;
	logic fits;
	logic signed [OUT_W-1:0] det_nxt;

	assign new_row = {entry_d[ENTRY_WIDTH-1:0], entry_c[ENTRY_WIDTH-1:0],
		entry_b[ENTRY_WIDTH-1:0], entry_a[ENTRY_WIDTH-1:0]};
	assign busy = (phase_q != PH_IDLE);

	// Input gating: row one starts the top minors and row three the rest.
	always_comb begin
		unique case (cnt_q)
			2'd0, 2'd2: in_stall = 1'b0;
			2'd1, 2'd3: in_stall = busy;
			default: in_stall = 1'b1;
		endcase
	end

	assign accept = in_valid & ~in_stall;

	// Operand selection for the current product.
	always_comb begin
		pidx = op_q[3:1];
		xcol = op_q[0] ? pair_hi(pidx) : pair_lo(pidx);
		ycol = op_q[0] ? pair_lo(pidx) : pair_hi(pidx);
		upper = (phase_q == PH_MTOP) ? row0_q : row2_q;
		lower = (phase_q == PH_MTOP) ? row1_q : row3_q;
		xe = upper[xcol];
		ye = lower[ycol];
		y_ent = YW'($signed(ye));
		mac_ctrl = '0;
		if (phase_q == PH_EXPAND) begin
			mac_x = m01_q[op_q[2:0]];
			mac_y = YW'(m23_q[pair_idx_t'(NPAIR - 1) - op_q[2:0]]);
			mac_ctrl.neg = pair_neg(op_q[2:0]);
			mac_ctrl.clear = (op_q == '0);
			mac_ctrl.long_op = 1'b1;
		end else begin
			mac_x = XW'($signed(xe));
			mac_y = y_ent <<< YSH;
			mac_ctrl.neg = op_q[0];
			mac_ctrl.clear = ~op_q[0];
			mac_ctrl.long_op = 1'b0;
		end
		mac_ctrl.start = ~inflight_q &
			(phase_q == PH_MTOP || phase_q == PH_MBOT || phase_q == PH_EXPAND);
	end

	mdet_serial_mac #(
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(mac_ctrl),
		.x_in(mac_x),
		.y_in(mac_y),
		.done(mac_done),
		.sum(mac_sum),
		.acc(mac_acc)
	);

	// Rescale the exact sum to Q32.32 and clip to 64 bits.
	always_comb begin
		wide_ext = WIDE_W'(mac_acc);
		scaled = (wide_ext <<< SHL) >>> SHR;
		hi_bits = scaled[WIDE_W-1:OUT_W-1];
		fits = (&hi_bits) | ~(|hi_bits);
		if (fits) begin
			det_nxt = scaled[OUT_W-1:0];
		end else if (scaled[WIDE_W-1]) begin
			det_nxt = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			det_nxt = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	// Sequencer next state.
	always_comb begin
		phase_d = phase_q;
		op_d = op_q;
		inflight_d = inflight_q;
		cnt_d = cnt_q;
		out_valid_d = out_valid_q;
		load_out = 1'b0;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		if (accept) begin
			cnt_d = cnt_q + 2'd1;
			if (cnt_q == 2'd1) begin
				phase_d = PH_MTOP;
				op_d = '0;
			end else if (cnt_q == 2'd3) begin
				phase_d = PH_MBOT;
				op_d = '0;
			end
		end
		unique case (phase_q)
			PH_IDLE: begin
			end
			PH_MTOP, PH_MBOT: begin
				if (!inflight_q) begin
					inflight_d = 1'b1;
				end else if (mac_done) begin
					inflight_d = 1'b0;
					if (op_q == LAST_MIN) begin
						phase_d = (phase_q == PH_MTOP) ? PH_IDLE : PH_EXPAND;
						op_d = '0;
					end else begin
						op_d = op_q + 4'd1;
					end
				end
			end
			PH_EXPAND: begin
				if (!inflight_q) begin
					inflight_d = 1'b1;
				end else if (mac_done) begin
					inflight_d = 1'b0;
					if (op_q == LAST_EXP) begin
						phase_d = PH_SCALE;
						op_d = '0;
					end else begin
						op_d = op_q + 4'd1;
					end
				end
			end
			PH_SCALE: begin
				// The result is loaded once the output register is empty.
				if (!out_valid_q) begin
					load_out = 1'b1;
					out_valid_d = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Sequencer and handshake state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			op_q <= '0;
			inflight_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			op_q <= op_d;
			inflight_q <= inflight_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Row store, minor registers and result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			case (cnt_q)
				2'd0: row0_q <= new_row;
				2'd1: row1_q <= new_row;
				2'd2: row2_q <= new_row;
				default: row3_q <= new_row;
			endcase
		end
		if (mac_done && op_q[0] && phase_q == PH_MTOP) begin
			m01_q[op_q[3:1]] <= mac_sum[XW-1:0];
		end
		if (mac_done && op_q[0] && phase_q == PH_MBOT) begin
			m23_q[op_q[3:1]] <= mac_sum[XW-1:0];
		end
		if (load_out) begin
			det_q <= det_nxt;
			sat_q <= ~fits;
		end
	end

	assign out_valid = out_valid_q;
	assign determinant = det_q;
	assign saturated = sat_q;

endmodule

// ===== hw/rtl/mdet_checker.sv =====
// ============================================================================
// mdet_checker: port-level checks for the 4x4 determinant unit
// Watches the top-level ports only and is attached by a bind statement.
// ============================================================================
module mdet_checker
	import mdet_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [OUT_W-1:0] determinant,
	input logic saturated
);

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(determinant) && $stable(saturated))
		else $error("stalled result changed");

	// A clipped result is one of the two range limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			determinant == {1'b1, {(OUT_W-1){1'b0}}} ||
			determinant == {1'b0, {(OUT_W-1){1'b1}}})
		else $error("saturated result is not a range limit");

	// Results cannot follow each other directly: a new one is loaded only
	// once the output register is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result delivered back to back");

	// Coming out of reset the unit takes the first row at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_stall)
		else $error("input stalled right after reset");

endmodule

bind matrix4_determinant_unit mdet_checker u_mdet_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.determinant(determinant),
	.saturated(saturated)
);
